FILE: rtl/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg: shared types, codes and helpers of the banked GPIO controller
// Transaction kinds, register codes, the lane command, status and result
// structs, the address decoder and the per-bank pin mask.
// ----------------------------------------------------------------------------
`default_nettype none

package bgc_pkg;

  // Transaction kinds
  localparam logic [1:0] FUNC_READ   = 2'd0;
  localparam logic [1:0] FUNC_WRITE  = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE = 2'd2;
  localparam logic [1:0] FUNC_NOP    = 2'd3;

  // Bank 1 is only 22 pins wide
  localparam logic [31:0] ALL_PINS   = 32'hFFFF_FFFF;
  localparam logic [31:0] BANK1_PINS = 32'h003F_FFFF;
  localparam logic [15:0] HALF_MASK  = 16'hFFFF;

  // Register map, byte offsets
  localparam logic [9:0] OFS_DATA    = 10'h040;
  localparam logic [9:0] OFS_DATA_RO = 10'h060;
  localparam logic [9:0] OFS_BLOCK   = 10'h200;

  typedef logic [3:0] reg_code_t;

  localparam reg_code_t REG_NONE    = 4'd0;
  localparam reg_code_t REG_MDATA   = 4'd1;
  localparam reg_code_t REG_DATA    = 4'd2;
  localparam reg_code_t REG_DATA_RO = 4'd3;
  localparam reg_code_t REG_DIRM    = 4'd4;
  localparam reg_code_t REG_OEN     = 4'd5;
  localparam reg_code_t REG_IMASK   = 4'd6;
  localparam reg_code_t REG_IEN     = 4'd7;
  localparam reg_code_t REG_IDIS    = 4'd8;
  localparam reg_code_t REG_ISTAT   = 4'd9;
  localparam reg_code_t REG_ITYPE   = 4'd10;
  localparam reg_code_t REG_IPOL    = 4'd11;
  localparam reg_code_t REG_IANY    = 4'd12;

  typedef struct packed {
    reg_code_t  code;
    logic       half;
    logic [2:0] bank;
  } reg_dec_t;

  // Command broadcast to every lane
  typedef struct packed {
    logic        valid;
    logic        rd;
    logic        wr;
    logic        smp;
    logic        mapped;
    reg_code_t   code;
    logic        half;
    logic [2:0]  bank;
    logic [1:0]  sbank;
    logic [31:0] wdata;
    logic [31:0] levels;
  } lane_cmd_t;

  // What one lane reports to the merge stage
  typedef struct packed {
    logic [31:0] rdata;
    logic        irq;
    logic [31:0] drive_levels;
    logic [31:0] drive_enables;
  } lane_stat_t;

  // Merged result of one transaction
  typedef struct packed {
    logic [31:0] rdata;
    logic        irq;
    logic [1:0]  dbank;
    logic [31:0] dlevels;
    logic [31:0] denables;
    logic        err;
  } result_t;

  function automatic logic [31:0] pins_of(input logic [2:0] bank);
    return (bank == 3'd1) ? BANK1_PINS : ALL_PINS;
  endfunction

  // Address decode; bank range is checked by the caller
  function automatic reg_dec_t decode_addr(input logic [9:0] addr);
    reg_dec_t d;
    d.code = REG_NONE;
    d.half = addr[2];
    d.bank = 3'd0;
    priority if (addr < OFS_DATA) begin
      d.code = REG_MDATA;
      d.bank = addr[5:3];
    end else if (addr < OFS_DATA_RO) begin
      d.code = REG_DATA;
      d.bank = addr[4:2];
    end else if (addr < OFS_DATA_RO + 10'h020) begin
      d.code = REG_DATA_RO;
      d.bank = addr[4:2];
    end else if (addr >= OFS_BLOCK) begin
      d.bank = addr[8:6];
      unique case (addr[5:2])
        4'd1:    d.code = REG_DIRM;
        4'd2:    d.code = REG_OEN;
        4'd3:    d.code = REG_IMASK;
        4'd4:    d.code = REG_IEN;
        4'd5:    d.code = REG_IDIS;
        4'd6:    d.code = REG_ISTAT;
        4'd7:    d.code = REG_ITYPE;
        4'd8:    d.code = REG_IPOL;
        4'd9:    d.code = REG_IANY;
        default: d.code = REG_NONE;
      endcase
    end else begin
      d.code = REG_NONE;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bgc_lane.sv
// ----------------------------------------------------------------------------
// bgc_lane: register file and interrupt logic of one GPIO bank
// Holds the bank's registers, applies bus writes and pin samples addressed to
// it, and reports read data, pending interrupt and pin drive.
// ----------------------------------------------------------------------------
`default_nettype none

module bgc_lane
  import bgc_pkg::*;
#(
  parameter int unsigned LANE = 0
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire lane_cmd_t  cmd,
  output lane_stat_t      stat
);

  localparam logic [2:0]  LANE_ID = 3'(LANE);
  localparam logic [31:0] PINS    = pins_of(LANE_ID);

  logic [31:0] out_data,     out_data_next;
  logic [31:0] direction,    direction_next;
  logic [31:0] out_enable,   out_enable_next;
  logic [31:0] irq_mask,     irq_mask_next;
  logic [31:0] irq_status,   irq_status_next;
  logic [31:0] irq_type,     irq_type_next;
  logic [31:0] irq_polarity, irq_polarity_next;
  logic [31:0] irq_any_edge, irq_any_edge_next;
  logic [31:0] last_levels,  last_levels_next;

  logic        wr_hit, smp_hit;
  logic [31:0] wmask, chg, dat, lv, rise, fall, edge_hit, level_hit;

  assign wr_hit  = cmd.valid && cmd.wr && cmd.mapped && (cmd.bank == LANE_ID);
  assign smp_hit = cmd.valid && cmd.smp && ({1'b0, cmd.sbank} == LANE_ID);

  // Masked half-word write: upper 16 bits are an inverted enable
  assign wmask = cmd.wdata & PINS;
  assign chg   = cmd.half ? {~cmd.wdata[31:16], 16'h0000} : {16'h0000, ~cmd.wdata[31:16]};
  assign dat   = cmd.half ? {cmd.wdata[15:0] & HALF_MASK, 16'h0000}
                          : {16'h0000, cmd.wdata[15:0] & HALF_MASK};

  // Edge and level detection for a sample
  assign lv        = cmd.levels & PINS;
  assign rise      = ~last_levels & lv;
  assign fall      = last_levels & ~lv;
  assign edge_hit  = (irq_any_edge & (rise | fall)) |
                     (~irq_any_edge & ((irq_polarity & rise) | (~irq_polarity & fall)));
  assign level_hit = (irq_polarity & lv) | (~irq_polarity & ~lv);

  // Next state
  always_comb begin
    out_data_next     = out_data;
    direction_next    = direction;
    out_enable_next   = out_enable;
    irq_mask_next     = irq_mask;
    irq_status_next   = irq_status;
    irq_type_next     = irq_type;
    irq_polarity_next = irq_polarity;
    irq_any_edge_next = irq_any_edge;
    last_levels_next  = last_levels;
    if (wr_hit) begin
      unique case (cmd.code)
        REG_MDATA: out_data_next     = ((out_data & ~chg) | (dat & chg)) & PINS;
        REG_DATA:  out_data_next     = wmask;
        REG_DIRM:  direction_next    = wmask;
        REG_OEN:   out_enable_next   = wmask;
        REG_IEN:   irq_mask_next     = irq_mask & ~wmask;
        REG_IDIS:  irq_mask_next     = irq_mask | wmask;
        REG_ISTAT: irq_status_next   = irq_status & ~wmask;
        REG_ITYPE: irq_type_next     = wmask;
        REG_IPOL:  irq_polarity_next = wmask;
        REG_IANY:  irq_any_edge_next = wmask;
        default:   ;
      endcase
    end
    if (smp_hit) begin
      irq_status_next  = irq_status |
                         (((irq_type & edge_hit) | (~irq_type & level_hit)) & PINS);
      last_levels_next = lv;
    end
  end

  // Bank registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_data     <= '0;
      direction    <= '0;
      out_enable   <= '0;
      irq_mask     <= PINS;
      irq_status   <= '0;
      irq_type     <= '0;
      irq_polarity <= '0;
      irq_any_edge <= '0;
      last_levels  <= '0;
    end else begin
      out_data     <= out_data_next;
      direction    <= direction_next;
      out_enable   <= out_enable_next;
      irq_mask     <= irq_mask_next;
      irq_status   <= irq_status_next;
      irq_type     <= irq_type_next;
      irq_polarity <= irq_polarity_next;
      irq_any_edge <= irq_any_edge_next;
      last_levels  <= last_levels_next;
    end
  end

  // Read mux, taken before any update of this transaction
  always_comb begin
    unique case (cmd.code)
      REG_MDATA:   stat.rdata = cmd.half ? {16'h0000, out_data[31:16]}
                                         : {16'h0000, out_data[15:0]};
      REG_DATA:    stat.rdata = out_data;
      REG_DATA_RO: stat.rdata = last_levels;
      REG_DIRM:    stat.rdata = direction;
      REG_OEN:     stat.rdata = out_enable;
      REG_IMASK:   stat.rdata = irq_mask;
      REG_ISTAT:   stat.rdata = irq_status;
      REG_ITYPE:   stat.rdata = irq_type;
      REG_IPOL:    stat.rdata = irq_polarity;
      REG_IANY:    stat.rdata = irq_any_edge;
      default:     stat.rdata = '0;
    endcase
  end

  // Status after the transaction
  assign stat.irq           = |(irq_status_next & ~irq_mask_next);
  assign stat.drive_levels  = out_data_next;
  assign stat.drive_enables = direction_next & out_enable_next;

endmodule

`default_nettype wire

FILE: rtl/bgc_merge.sv
// ----------------------------------------------------------------------------
// bgc_merge: combines the lane reports into one result
// Selects read data and pin drive from the addressed bank, ORs the interrupt
// requests and flags unmapped accesses.
// ----------------------------------------------------------------------------
`default_nettype none

module bgc_merge
  import bgc_pkg::*;
#(
  parameter int unsigned NUM_BANKS = 4
) (
  input  wire lane_cmd_t  cmd,
  input  wire lane_stat_t lanes [NUM_BANKS],
  output result_t         res
);

  logic [2:0] touched;
  logic [1:0] dbank;

  // Bank reported on the drive outputs
  always_comb begin
    priority if ((cmd.rd || cmd.wr) && cmd.mapped) begin
      touched = cmd.bank;
    end else if (cmd.smp) begin
      touched = {1'b0, cmd.sbank};
    end else begin
      touched = 3'd0;
    end
  end

  assign dbank = touched[1:0];

  // Lane selection and interrupt OR
  always_comb begin
    res.rdata    = '0;
    res.irq      = 1'b0;
    res.dlevels  = '0;
    res.denables = '0;
    for (int unsigned i = 0; i < NUM_BANKS; i++) begin
      if (cmd.rd && cmd.mapped && (cmd.bank == 3'(i))) begin
        res.rdata = res.rdata | lanes[i].rdata;
      end
      res.irq = res.irq | lanes[i].irq;
      if ({1'b0, dbank} == 3'(i)) begin
        res.dlevels  = res.dlevels | lanes[i].drive_levels;
        res.denables = res.denables | lanes[i].drive_enables;
      end
    end
  end

  assign res.dbank = dbank;
  assign res.err   = (cmd.rd || cmd.wr) && !cmd.mapped;

endmodule

`default_nettype wire

FILE: rtl/banked_gpio_controller.sv
// ----------------------------------------------------------------------------
// banked_gpio_controller: banked GPIO controller top level
// Decodes bus and sample transactions, runs one lane per bank side by side
// and registers the merged result on the output channel.
// ----------------------------------------------------------------------------
// A result is registered when its transaction is accepted and is valid in the next cycle.
// Throughput: one transaction per cycle; a new one is taken whenever the
// output register is empty or is being emptied in the same cycle.
// The update path is one bitwise pass through the addressed bank's lane.
// Reset: all bank registers clear, interrupt masks set over existing pins,
// the output register empties.
`default_nettype none

module banked_gpio_controller
  import bgc_pkg::*;
#(
  parameter int unsigned NUM_BANKS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [9:0]  addr,
  input  wire logic [31:0] wdata,
  input  wire logic [1:0]  sample_bank,
  input  wire logic [31:0] pin_levels,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      read_data,
  output logic             irq_out,
  output logic [1:0]       drive_bank,
  output logic [31:0]      drive_levels,
  output logic [31:0]      drive_enables,
  output logic             access_error
);

  logic       in_accept;
  reg_dec_t   dec;
  lane_cmd_t  cmd;
  lane_stat_t lanes [NUM_BANKS];
  result_t    res;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // Decode and build the lane command
  assign dec = decode_addr({addr[9:2], 2'b00});

  always_comb begin
    cmd.valid  = in_accept;
    cmd.rd     = (func == FUNC_READ);
    cmd.wr     = (func == FUNC_WRITE);
    cmd.smp    = (func == FUNC_SAMPLE);
    cmd.mapped = (dec.code != REG_NONE) && ({1'b0, dec.bank} < 4'(NUM_BANKS));
    cmd.code   = dec.code;
    cmd.half   = dec.half;
    cmd.bank   = dec.bank;
    cmd.sbank  = sample_bank;
    cmd.wdata  = wdata;
    cmd.levels = pin_levels;
  end

  // One lane per bank
  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_lane
    bgc_lane #(
      .LANE(g)
    ) u_lane (
      .clk  (clk),
      .rst  (rst),
      .cmd  (cmd),
      .stat (lanes[g])
    );
  end

  bgc_merge #(
    .NUM_BANKS(NUM_BANKS)
  ) u_merge (
    .cmd   (cmd),
    .lanes (lanes),
    .res   (res)
  );

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      read_data     <= res.rdata;
      irq_out       <= res.irq;
      drive_bank    <= res.dbank;
      drive_levels  <= res.dlevels;
      drive_enables <= res.denables;
      access_error  <= res.err;
    end
  end

  // Checks
  a_empty_after_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("output valid straight after reset");

  a_read_only_data: assert property (@(posedge clk) disable iff (rst)
    in_accept && (func != FUNC_READ) |=> read_data == '0)
    else $error("read data set by a transaction that is not a read");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && access_error |-> (read_data == '0) && (drive_bank == 2'd0))
    else $error("unmapped access reports data or a bank");

  a_nop_no_error: assert property (@(posedge clk) disable iff (rst)
    in_accept && ((func == FUNC_SAMPLE) || (func == FUNC_NOP)) |=> !access_error)
    else $error("access error on a sample or no-op");

endmodule

`default_nettype wire
